// ===== src/aabb_frustum_cull_macros.svh =====
// Assertion macros shared by the box culling RTL.
// Included by the top level, the only module that carries concurrent assertions; no other dependencies.
`ifndef AABB_FRUSTUM_CULL_MACROS_SVH
`define AABB_FRUSTUM_CULL_MACROS_SVH

`ifndef ASSERT_OFF
// Checked only while reset is released.
`define AFC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("%m: assertion failed");
// Checked at every edge, reset included.
`define AFC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");
`else
`define AFC_ASSERT(lbl, clk, rstn, prop)
`define AFC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== src/afc_pkg.sv =====
// Shared types and constants for the box versus frustum culling block.
// No dependencies; imported by afc_plane_unit and the top level, and referenced by afc_box_if.
package afc_pkg;

  localparam int PLANE_COUNT_DEF = 6;
  localparam int COORD_BITS_DEF  = 16;
  localparam int NUM_PLANE_REGS  = 6;
  localparam int PLANE_W         = 64;
  localparam int COMP_W          = 16;
  localparam int OFFSET_SHIFT    = 8;
  localparam int REG_IDX_W       = 3;
  localparam int CFG_ADDR_W      = 6;
  localparam int CFG_BYTE_SHIFT  = 3;

  typedef logic [PLANE_W-1:0] afc_plane_t;

  // Advance enables for the two stages held inside each plane unit.
  typedef struct packed {
    logic mul_en;
    logic sum_en;
  } afc_stage_ctrl_t;

endpackage

// ===== src/afc_box_if.sv =====
// Valid/ready channel carrying one axis-aligned box as min and max corners.
// Depends on afc_pkg for the default coordinate width.
interface afc_box_if #(
  parameter int COORD_BITS = afc_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] min_x;
  logic signed [COORD_BITS-1:0] min_y;
  logic signed [COORD_BITS-1:0] min_z;
  logic signed [COORD_BITS-1:0] max_x;
  logic signed [COORD_BITS-1:0] max_y;
  logic signed [COORD_BITS-1:0] max_z;

  modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z, input ready);
  modport sink   (input valid, min_x, min_y, min_z, max_x, max_y, max_z, output ready);
endinterface

// ===== src/afc_vis_if.sv =====
// Valid/ready channel carrying the visibility verdict for one box.
// No dependencies.
interface afc_vis_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink   (input valid, visible, output ready);
endinterface

// ===== src/afc_plane_unit.sv =====
// One plane of the culling test: corner select, three products, then sum and sign.
// Depends on afc_pkg; pipeline enables come from the top level.
module afc_plane_unit #(
  parameter int COORD_BITS = afc_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  afc_pkg::afc_stage_ctrl_t     ctrl,
  input  afc_pkg::afc_plane_t          plane,
  input  logic signed [COORD_BITS-1:0] lo_x,
  input  logic signed [COORD_BITS-1:0] lo_y,
  input  logic signed [COORD_BITS-1:0] lo_z,
  input  logic signed [COORD_BITS-1:0] hi_x,
  input  logic signed [COORD_BITS-1:0] hi_y,
  input  logic signed [COORD_BITS-1:0] hi_z,
  output logic                         neg
);
  import afc_pkg::*;

  localparam int PROD_W = COMP_W + COORD_BITS;
  localparam int SUM_W  = PROD_W + 2;

  logic signed [COMP_W-1:0]     nx, ny, nz, d;
  logic signed [COORD_BITS-1:0] cx, cy, cz;
  logic signed [PROD_W-1:0]     px, py, pz;
  logic signed [PROD_W-1:0]     px_r, py_r, pz_r;
  logic signed [COMP_W-1:0]     d_r;
  logic signed [SUM_W-1:0]      sum;
  logic                         neg_r;

  assign nx = plane[COMP_W-1:0];
  assign ny = plane[2*COMP_W-1:COMP_W];
  assign nz = plane[3*COMP_W-1:2*COMP_W];
  assign d  = plane[4*COMP_W-1:3*COMP_W];

  // Positive vertex: a non-negative normal component takes the max coordinate.
  assign cx = nx[COMP_W-1] ? lo_x : hi_x;
  assign cy = ny[COMP_W-1] ? lo_y : hi_y;
  assign cz = nz[COMP_W-1] ? lo_z : hi_z;

  assign px = PROD_W'(nx) * PROD_W'(cx);
  assign py = PROD_W'(ny) * PROD_W'(cy);
  assign pz = PROD_W'(nz) * PROD_W'(cz);

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      px_r <= px;
      py_r <= py;
      pz_r <= pz;
      d_r  <= d;
    end
  end

  // The offset is Q8.8 and moves to Q16.16 to line up with the products.
  assign sum = SUM_W'(px_r) + SUM_W'(py_r) + SUM_W'(pz_r)
             + (SUM_W'(d_r) <<< OFFSET_SHIFT);

  always_ff @(posedge clk) begin
    if (ctrl.sum_en) begin
      neg_r <= sum[SUM_W-1];
    end
  end

  assign neg = neg_r;

endmodule

// ===== src/aabb_frustum_cull.sv =====
// Top level of the axis-aligned box versus frustum culling block.
// Depends on afc_pkg, afc_box_if, afc_vis_if, afc_plane_unit and the assertion macros.
//
// Usage:
//   in_box carries one box per transaction as signed Q8.8 min and max corners.
//   out_res returns one transaction per box, in order, with visible set when no
//   tested plane puts the box fully on its negative side.
//   The six planes are written over the APB-style port, one 64-bit register per
//   plane at byte address 8*i, packed as a, b, c, d in 16-bit slices. Planes
//   should only be written while no box is in flight.
//
// Timing:
//   Four register stages: input register, corner select and multiply, sum and
//   sign, output register. An accepted box passes through them in that order, and
//   one box is accepted per cycle, sustained, while out_res.ready stays high.
// Reset (synchronous, active low) clears all valid bits and the plane registers,
// so every box is visible until planes are written. A stalled receiver makes each
// stage hold; bubbles fill first, and in_box.ready drops once all four stages are full.
`include "aabb_frustum_cull_macros.svh"

module aabb_frustum_cull #(
  parameter int PLANE_COUNT = afc_pkg::PLANE_COUNT_DEF,
  parameter int COORD_BITS  = afc_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  afc_box_if.sink                            in_box,
  afc_vis_if.source                          out_res,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [afc_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [afc_pkg::PLANE_W-1:0]        pwdata,
  output logic [afc_pkg::PLANE_W-1:0]        prdata,
  output logic                               pready
);
  import afc_pkg::*;

  // ---------------------------------------------------------------------------
  // Plane registers. The register index is the address with the byte offset
  // dropped; indexes past the last plane are ignored on write and read as 0.
  // ---------------------------------------------------------------------------
  afc_plane_t               plane_r [NUM_PLANE_REGS];
  logic [REG_IDX_W-1:0]     reg_idx;
  logic                     reg_hit;
  logic                     cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:CFG_BYTE_SHIFT];
  assign reg_hit = (32'(reg_idx) < NUM_PLANE_REGS);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PLANE_REGS; i++) begin
        plane_r[i] <= '0;
      end
    end else if (cfg_wr && reg_hit) begin
      plane_r[reg_idx] <= pwdata;
    end
  end

  assign prdata = reg_hit ? plane_r[reg_idx] : '0;

  // ---------------------------------------------------------------------------
  // Pipeline control. Each stage advances when it is empty or the stage after
  // it advances, so bubbles collapse and a stalled output backs up one stage
  // at a time.
  // ---------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy4;
  afc_stage_ctrl_t unit_ctrl;

  assign rdy4 = !out_valid_r || out_res.ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign in_box.ready     = rdy1;
  assign unit_ctrl.mul_en = rdy2;
  assign unit_ctrl.sum_en = rdy3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_box.valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        out_valid_r <= v3_r;
      end
    end
  end

  // Stage 1: box register.
  logic signed [COORD_BITS-1:0] lo_x_r, lo_y_r, lo_z_r, hi_x_r, hi_y_r, hi_z_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      lo_x_r <= in_box.min_x;
      lo_y_r <= in_box.min_y;
      lo_z_r <= in_box.min_z;
      hi_x_r <= in_box.max_x;
      hi_y_r <= in_box.max_y;
      hi_z_r <= in_box.max_z;
    end
  end

  // Stages 2 and 3: one unit per tested plane. Planes are not copied into the
  // pipeline, so the user must only change them while it is empty; the block does not enforce this.
  logic [PLANE_COUNT-1:0] plane_neg;

  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
    afc_plane_unit #(
      .COORD_BITS(COORD_BITS)
    ) u_plane (
      .clk  (clk),
      .ctrl (unit_ctrl),
      .plane(plane_r[p]),
      .lo_x (lo_x_r),
      .lo_y (lo_y_r),
      .lo_z (lo_z_r),
      .hi_x (hi_x_r),
      .hi_y (hi_y_r),
      .hi_z (hi_z_r),
      .neg  (plane_neg[p])
    );
  end

  // Stage 4: output register. A single negative plane culls the box; a box
  // that touches a plane exactly stays visible.
  logic visible_r;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      visible_r <= ~|plane_neg;
    end
  end

  assign out_res.valid   = out_valid_r;
  assign out_res.visible = visible_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `AFC_ASSERT_ALWAYS(a_reset_clears, clk,
    !rst_n |=> !v1_r && !v2_r && !v3_r && !out_valid_r)
  `AFC_ASSERT(a_accept_loads, clk, rst_n,
    in_box.valid && in_box.ready |=> v1_r)
  `AFC_ASSERT(a_full_blocks_input, clk, rst_n,
    out_valid_r && !out_res.ready && v3_r && v2_r && v1_r |-> !in_box.ready)
  `AFC_ASSERT(a_last_stage_drains, clk, rst_n,
    v3_r && rdy4 |=> out_valid_r)

endmodule
